### design/pvd_pkg.sv
// Package with shared constants, codes and types of the decimated peak and valley detector.
`default_nettype none

package pvd_pkg;

    // Field widths of the channels.
    localparam int SAMPLE_BITS   = 16;
    localparam int TIME_BITS     = 30;
    localparam int OUT_TIME_BITS = 32;
    localparam int KIND_BITS     = 2;
    localparam int COUNT_BITS    = 16;
    localparam int LEN_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Detection window in averages and the default width of the index counters.
    localparam int SEARCH_WINDOW  = 2000;
    localparam int INDEX_BITS_DEF = 24;

    // Block sums: up to 255 samples or time stamps.
    localparam int VSUM_BITS = SAMPLE_BITS + LEN_BITS;
    localparam int TSUM_BITS = TIME_BITS + LEN_BITS;

    // The averaged time is reported times four.
    localparam int TIME_SCALE_SHIFT = 2;

    // Divider step counter holds up to the widest dividend.
    localparam int DIV_STEP_BITS = $clog2(TSUM_BITS + 1);

    // Reset value of the block length register.
    localparam logic [LEN_BITS-1:0] BLOCK_LENGTH_RESET = 8'd16;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_AVG   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PEAK  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_FINAL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_LENGTH       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_PEAK_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_BOTTOM_LIMIT = 2'd2;

    // Request to the shared divider.
    typedef struct packed {
        logic                     start;
        logic [DIV_STEP_BITS-1:0] steps;
    } t_div_req;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

### design/pvd_if.sv
// Channel interfaces of the detector: sample input, result output and register writes.
`default_nettype none

// Raw sample channel.
interface pvd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pvd_pkg::SAMPLE_BITS-1:0]  sample;
    logic        [pvd_pkg::TIME_BITS-1:0]    time_stamp;
    logic                                    last_sample;

    modport source (output valid, output sample, output time_stamp, output last_sample,
                    input ready);
    modport sink   (input valid, input sample, input time_stamp, input last_sample,
                    output ready);
endinterface

// Result channel.
interface pvd_out_if;
    logic                                     valid;
    logic                                     ready;
    logic        [pvd_pkg::KIND_BITS-1:0]     kind;
    logic        [pvd_pkg::OUT_TIME_BITS-1:0] time_out;
    logic signed [pvd_pkg::SAMPLE_BITS-1:0]   value;
    logic        [pvd_pkg::COUNT_BITS-1:0]    peak_count;
    logic                                     last;

    modport source (output valid, output kind, output time_out, output value,
                    output peak_count, output last, input ready);
    modport sink   (input valid, input kind, input time_out, input value,
                    input peak_count, input last, output ready);
endinterface

// Register write channel.
interface pvd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pvd_pkg::CFG_IDX_BITS-1:0]    index;
    logic [pvd_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/pvd_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none

module pvd_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pvd_pkg::t_div_req                i_req,
    input  wire logic [pvd_pkg::TSUM_BITS-1:0]    i_dividend,
    input  wire logic [pvd_pkg::LEN_BITS-1:0]     i_divisor,
    output pvd_pkg::t_div_stat                    o_stat,
    output logic [pvd_pkg::TSUM_BITS-1:0]         o_quotient
);

    localparam int DW = pvd_pkg::TSUM_BITS;
    localparam int LW = pvd_pkg::LEN_BITS;

    logic                              r_busy;
    logic                              r_done;
    logic [pvd_pkg::DIV_STEP_BITS-1:0] r_steps;
    logic [LW-1:0]                     r_rem;
    logic [LW-1:0]                     r_divisor;
    logic [DW-1:0]                     r_dvd;

    logic [LW:0]   w_shift;
    logic [LW+1:0] w_diff;
    logic          w_fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        w_shift = {r_rem, r_dvd[DW-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_divisor};
        w_fits  = ~w_diff[LW+1];
    end

    // Control: busy while steps remain, done pulses once after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= i_req.steps;
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == pvd_pkg::DIV_STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in at the bottom as dividend bits leave the top.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_dvd     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[LW-1:0] : w_shift[LW-1:0];
            r_dvd <= {r_dvd[DW-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_dvd;

endmodule

`default_nettype wire

### design/decimated_peak_valley_detector.sv
// Top level: block averaging, peak tracking with hysteresis and result sequencing.
//
//  Channel   Dir  Beat contents                                 Handshake
//  i_in      in   sample, time_stamp, last_sample               valid/ready
//  o_out     out  kind, time_out, value, peak_count, last       valid/ready
//  i_cfg     in   index, data (block length, peak/bottom limits) valid/ready, always ready
//
//  A sample that does not close a block is accumulated while idle; unless it ends its record,
//  the next can follow at once. A closing sample goes through the 38-bit time division, then
//  the 24-bit value division in the one-bit-per-cycle shared divider, then an evaluation state
//  and one emit state per result; a last sample adds the final peak state. Reset is
//  synchronous, active low, clears all record state and the limits, and sets block length 16.
//  A stalled output holds the sequencer in its emit state; the output register lets a new
//  sample be taken while the last result of the previous one still waits.
`default_nettype none

module decimated_peak_valley_detector #(
    parameter int INDEX_BITS = pvd_pkg::INDEX_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pvd_in_if.sink     i_in,
    pvd_out_if.source  o_out,
    pvd_cfg_if.sink    i_cfg
);

    localparam int VW = pvd_pkg::VSUM_BITS;
    localparam int TW = pvd_pkg::TSUM_BITS;
    localparam int SW = pvd_pkg::SAMPLE_BITS;
    localparam int OW = pvd_pkg::OUT_TIME_BITS;
    localparam int LW = pvd_pkg::LEN_BITS;
    localparam int CW = pvd_pkg::COUNT_BITS;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DIV_T     = 7'b0000010,
        S_DIV_V     = 7'b0000100,
        S_EVAL      = 7'b0001000,
        S_EMIT_AVG  = 7'b0010000,
        S_EMIT_PEAK = 7'b0100000,
        S_FIN       = 7'b1000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic        [LW-1:0] r_block_length;
    logic signed [SW-1:0] r_lower_peak_limit;
    logic signed [SW-1:0] r_upper_bottom_limit;

    // Record state.
    logic signed [VW-1:0]         r_value_sum;
    logic        [TW-1:0]         r_time_sum;
    logic        [LW-1:0]         r_block_fill;
    logic signed [VW-1:0]         r_prev_avg0;
    logic signed [VW-1:0]         r_prev_avg1;
    logic        [OW-1:0]         r_prev_time;
    logic        [INDEX_BITS-1:0] r_averages_seen;
    logic signed [VW-1:0]         r_cand_value;
    logic        [OW-1:0]         r_cand_time;
    logic        [INDEX_BITS-1:0] r_cand_index;
    logic                         r_cand_pending;
    logic        [CW-1:0]         r_reported_count;

    // Per-sample working registers.
    logic                 r_fin;
    logic signed [VW-1:0] r_value_hold;
    logic signed [VW-1:0] r_avg;
    logic        [OW-1:0] r_avg_time;
    logic                 r_confirm;
    logic                 r_new_peak;
    logic                 r_final_due;

    // Output register.
    logic                 r_out_valid;
    logic [pvd_pkg::KIND_BITS-1:0] r_out_kind;
    logic [OW-1:0]        r_out_time;
    logic signed [SW-1:0] r_out_value;
    logic [CW-1:0]        r_out_count;
    logic                 r_out_last;

    // Combinational signals.
    logic                 w_in_acc;
    logic signed [VW-1:0] n_value_sum;
    logic        [TW-1:0] n_time_sum;
    logic        [LW-1:0] n_block_fill;
    logic        [LW-1:0] w_len;
    logic                 w_close;
    logic        [VW-1:0] w_value_mag;
    logic signed [VW-1:0] w_quot_v;
    logic [INDEX_BITS-1:0] w_idx_next;
    logic                 w_confirm;
    logic                 w_new_peak;
    logic [CW-1:0]        w_count_inc;
    logic                 w_out_free;
    logic                 w_out_load;
    logic                 w_apply;
    logic                 w_clear;
    logic [pvd_pkg::KIND_BITS-1:0] n_out_kind;
    logic [OW-1:0]        n_out_time;
    logic signed [SW-1:0] n_out_value;
    logic [CW-1:0]        n_out_count;
    logic                 n_out_last;

    pvd_pkg::t_div_req    w_div_req;
    pvd_pkg::t_div_stat   w_div_stat;
    logic [TW-1:0]        w_dividend;
    logic [TW-1:0]        w_quotient;

    // Register writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length       <= pvd_pkg::BLOCK_LENGTH_RESET;
            r_lower_peak_limit   <= '0;
            r_upper_bottom_limit <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pvd_pkg::REG_BLOCK_LENGTH:       r_block_length       <= i_cfg.data[LW-1:0];
                pvd_pkg::REG_LOWER_PEAK_LIMIT:   r_lower_peak_limit   <= i_cfg.data;
                pvd_pkg::REG_UPPER_BOTTOM_LIMIT: r_upper_bottom_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Accumulation of the incoming beat and block close detection.
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid & i_in.ready;

    always_comb begin
        n_value_sum  = r_value_sum + VW'(i_in.sample);
        n_time_sum   = r_time_sum + TW'(i_in.time_stamp);
        n_block_fill = r_block_fill + 1'b1;
        w_len        = (r_block_length == '0) ? LW'(1) : r_block_length;
        w_close      = (n_block_fill >= w_len);
    end

    // Divider requests: time sum first, then the magnitude of the value sum.
    always_comb begin
        w_value_mag     = r_value_hold[VW-1] ? VW'(-r_value_hold) : VW'(r_value_hold);
        w_div_req.start = (w_in_acc && w_close) || (r_state == S_DIV_T && w_div_stat.done);
        if (r_state == S_IDLE) begin
            w_div_req.steps = pvd_pkg::DIV_STEP_BITS'(TW);
            w_dividend      = n_time_sum;
        end else begin
            w_div_req.steps = pvd_pkg::DIV_STEP_BITS'(VW);
            w_dividend      = {w_value_mag, {(TW - VW){1'b0}}};
        end
        w_quot_v = w_quotient[VW-1:0];
    end

    pvd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_len),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // Confirmation and local peak decisions on the newest average.
    always_comb begin
        w_idx_next = (r_cand_pending && r_cand_index != '1) ?
                     r_cand_index + INDEX_BITS'(1) : r_cand_index;
        w_confirm  = r_cand_pending && (r_averages_seen != '0) && (w_idx_next != '0) &&
                     (64'(w_idx_next) < 64'(pvd_pkg::SEARCH_WINDOW)) &&
                     (r_prev_avg0 < r_upper_bottom_limit) && (r_avg > r_prev_avg0);
        w_new_peak = (r_averages_seen >= INDEX_BITS'(2)) && (r_prev_avg0 >= r_prev_avg1) &&
                     (r_prev_avg0 >= r_avg) && (r_prev_avg0 > r_lower_peak_limit);
        w_count_inc = (r_reported_count == '1) ? r_reported_count
                                                : r_reported_count + 1'b1;
    end

    // Result selection and the points where the record state moves on.
    always_comb begin
        w_out_free  = ~r_out_valid | o_out.ready;
        w_out_load  = 1'b0;
        n_out_kind  = pvd_pkg::KIND_AVG;
        n_out_time  = r_avg_time;
        n_out_value = r_avg[SW-1:0];
        n_out_count = r_reported_count;
        n_out_last  = 1'b0;
        unique case (r_state)
            S_EMIT_AVG: begin
                w_out_load = w_out_free;
                n_out_last = ~r_confirm & ~r_final_due;
            end
            S_EMIT_PEAK: begin
                w_out_load  = w_out_free;
                n_out_kind  = pvd_pkg::KIND_PEAK;
                n_out_time  = r_cand_time;
                n_out_value = r_cand_value[SW-1:0];
                n_out_count = w_count_inc;
                n_out_last  = ~r_final_due;
            end
            S_FIN: begin
                w_out_load  = w_out_free & r_cand_pending;
                n_out_kind  = pvd_pkg::KIND_FINAL;
                n_out_time  = r_cand_time;
                n_out_value = r_cand_value[SW-1:0];
                n_out_count = w_count_inc;
                n_out_last  = 1'b1;
            end
            default: ;
        endcase
        w_apply = w_out_free && ((r_state == S_EMIT_AVG && !r_confirm) ||
                                 (r_state == S_EMIT_PEAK));
        w_clear = (r_state == S_FIN) && (!r_cand_pending || w_out_free);
    end

    // Sequencer and record state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_value_sum      <= '0;
            r_time_sum       <= '0;
            r_block_fill     <= '0;
            r_prev_avg0      <= '0;
            r_prev_avg1      <= '0;
            r_prev_time      <= '0;
            r_averages_seen  <= '0;
            r_cand_value     <= '0;
            r_cand_time      <= '0;
            r_cand_index     <= '0;
            r_cand_pending   <= 1'b0;
            r_reported_count <= '0;
            r_fin            <= 1'b0;
            r_confirm        <= 1'b0;
            r_new_peak       <= 1'b0;
            r_final_due      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_fin <= i_in.last_sample;
                        if (w_close) begin
                            r_value_hold <= n_value_sum;
                            r_value_sum  <= '0;
                            r_time_sum   <= '0;
                            r_block_fill <= '0;
                            r_state      <= S_DIV_T;
                        end else begin
                            r_value_sum  <= n_value_sum;
                            r_time_sum   <= n_time_sum;
                            r_block_fill <= n_block_fill;
                            r_state      <= i_in.last_sample ? S_FIN : S_IDLE;
                        end
                    end
                end
                S_DIV_T: begin
                    if (w_div_stat.done) begin
                        r_avg_time <= {w_quotient[OW-pvd_pkg::TIME_SCALE_SHIFT-1:0],
                                       {pvd_pkg::TIME_SCALE_SHIFT{1'b0}}};
                        r_state    <= S_DIV_V;
                    end
                end
                S_DIV_V: begin
                    if (w_div_stat.done) begin
                        r_avg   <= r_value_hold[VW-1] ? -w_quot_v : w_quot_v;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_confirm    <= w_confirm;
                    r_new_peak   <= w_new_peak;
                    r_final_due  <= r_fin && ((r_cand_pending && !w_confirm) || w_new_peak);
                    r_cand_index <= w_idx_next;
                    r_state      <= S_EMIT_AVG;
                end
                S_EMIT_AVG: begin
                    if (w_out_free) begin
                        if (r_confirm) begin
                            r_state <= S_EMIT_PEAK;
                        end else begin
                            r_state <= r_fin ? S_FIN : S_IDLE;
                        end
                    end
                end
                S_EMIT_PEAK: begin
                    if (w_out_free) begin
                        r_reported_count <= w_count_inc;
                        r_cand_pending   <= 1'b0;
                        r_state          <= r_fin ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    if (w_clear) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // The new average enters the history; a new local peak replaces the candidate.
            if (w_apply) begin
                if (r_new_peak) begin
                    r_cand_value   <= r_prev_avg0;
                    r_cand_time    <= r_prev_time;
                    r_cand_index   <= '0;
                    r_cand_pending <= 1'b1;
                end
                r_prev_avg1 <= r_prev_avg0;
                r_prev_avg0 <= r_avg;
                r_prev_time <= r_avg_time;
                if (r_averages_seen != '1) begin
                    r_averages_seen <= r_averages_seen + INDEX_BITS'(1);
                end
            end

            // End of record: drop the partial block and start over.
            if (w_clear) begin
                r_value_sum      <= '0;
                r_time_sum       <= '0;
                r_block_fill     <= '0;
                r_prev_avg0      <= '0;
                r_prev_avg1      <= '0;
                r_prev_time      <= '0;
                r_averages_seen  <= '0;
                r_cand_value     <= '0;
                r_cand_time      <= '0;
                r_cand_index     <= '0;
                r_cand_pending   <= 1'b0;
                r_reported_count <= '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind  <= n_out_kind;
            r_out_time  <= n_out_time;
            r_out_value <= n_out_value;
            r_out_count <= n_out_count;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.time_out   = r_out_time;
    assign o_out.value      = r_out_value;
    assign o_out.peak_count = r_out_count;
    assign o_out.last       = r_out_last;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV_T || r_state == S_DIV_V))
        else $error("divider finished outside a division state");

    // A started division keeps the divider busy in the next cycle.
    a_div_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> w_div_stat.busy)
        else $error("divider not busy after start");

    // An open block never holds the maximum fill.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block_fill != '1)
        else $error("block fill out of range");

    // Every peak beat counts itself.
    a_peak_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != pvd_pkg::KIND_AVG) |-> (r_out_count != '0))
        else $error("peak beat with zero peak count");

endmodule

`default_nettype wire
